FILE: hw/rtl/dcug_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dcug_pkg;

	localparam int unsigned DEF_TIME_BITS   = 32;
	localparam int unsigned DEF_MAX_PAYLOAD = 256;

	localparam int unsigned NOW_W = 32;
	localparam int unsigned LEN_W = 9;
	localparam int unsigned PCT_W = 7;

	localparam logic [PCT_W-1:0] PCT_FULL  = 7'd100;
	localparam logic [PCT_W-1:0] PCT_RESET = 7'd35;

	typedef enum logic [1:0] {
		OP_TICK     = 2'd0,
		OP_DOWNLINK = 2'd1,
		OP_QUEUE    = 2'd2,
		OP_NONE     = 2'd3
	} op_t;

	typedef struct packed {
		op_t              opcode;
		logic [NOW_W-1:0] now_ms;
		logic             radio_busy;
		logic [LEN_W-1:0] queue_length;
	} item_in_t;

	typedef struct packed {
		logic             send_fire;
		logic [LEN_W-1:0] send_length;
		logic             in_window;
		logic [NOW_W-1:0] cadence_ms;
		logic             pending;
	} item_out_t;

endpackage

`default_nettype wire

FILE: hw/rtl/dcug_div.sv
`timescale 1ns / 1ps
`default_nettype none

module dcug_div #(
	parameter int unsigned W = 32
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	input  wire logic [W-1:0] dividend,
	input  wire logic [W-1:0] divisor,
	output logic              done,
	output logic [W-1:0]      quotient,
	output logic [W-1:0]      remainder
);

	localparam int unsigned CW = $clog2(W + 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [W-1:0]  rem_q;
	logic [W-1:0]  quo_q;
	logic [W-1:0]  div_q;
	logic [W:0]    shifted;
	logic [W:0]    trial;

	// Restoring division: one quotient bit per cycle, MSB first.
	assign shifted = {rem_q, quo_q[W-1]};
	assign trial   = shifted - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CW'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= trial[W] ? shifted[W-1:0] : trial[W-1:0];
			quo_q <= {quo_q[W-2:0], ~trial[W]};
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !start)
		else $error("divider restarted while busy");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q)
		else $error("divider done while still iterating");

	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && div_q != '0) |-> (rem_q < div_q))
		else $error("divider remainder not below divisor");

	a_cnt_live: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (cnt_q != '0))
		else $error("divider busy with empty count");

endmodule

`default_nettype wire

FILE: hw/rtl/downlink_cadence_uplink_gate_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Downlink cadence uplink gate.
// Input channel (in_valid/in_ready/in_data) takes one event per transaction:
// a tick, a received downlink, or a new uplink to queue. Every event yields
// exactly one transaction on the output channel (out_valid/out_ready/out_data)
// telling whether the queued uplink fires, whether now lies in the safe window,
// the learned period and whether an uplink stays queued.
// The safe part of the period in percent is written over cfg_valid/cfg_data;
// cfg_ready is always high, and writes are meant for idle times only.
// Events are handled one at a time. All divisions share one bit-serial divider
// that retires one quotient bit per cycle. An event skips the divider while no
// period is learned, a window check uses it once, and a downlink that refines
// a known period uses it three times, one division after the other.
// The next event is taken once the previous result sits in the output register.
// Reset clears the anchor, the period and the queue and sets the percent to 35.
// A stalled receiver holds the result in the output register; a finished
// event then waits in its last state and no new event is taken.

module downlink_cadence_uplink_gate_top
	import dcug_pkg::*;
#(
	parameter int unsigned TIME_BITS   = DEF_TIME_BITS,
	parameter int unsigned MAX_PAYLOAD = DEF_MAX_PAYLOAD
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire item_in_t         in_data,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output item_out_t             out_data,
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic [PCT_W-1:0] cfg_data
);

	localparam int unsigned TW      = TIME_BITS;
	localparam int unsigned PW      = TW + PCT_W;
	localparam int unsigned LEN_CAP = (MAX_PAYLOAD > 511) ? 511 : MAX_PAYLOAD;
	localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(LEN_CAP);

	typedef enum logic [8:0] {
		S_IDLE   = 9'b000000001,
		S_PREP   = 9'b000000010,
		S_QUOT   = 9'b000000100,
		S_IMPL   = 9'b000001000,
		S_SMOOTH = 9'b000010000,
		S_WIN    = 9'b000100000,
		S_MOD    = 9'b001000000,
		S_MUL    = 9'b010000000,
		S_DONE   = 9'b100000000
	} state_t;

	state_t           state_q;
	op_t              op_q;
	logic [TW-1:0]    now_q;
	logic             radio_busy_q;
	logic [TW-1:0]    anchor_q;
	logic             anchor_vld_q;
	logic [TW-1:0]    period_q;
	logic [LEN_W-1:0] queued_q;
	logic [PCT_W-1:0] pct_q;
	logic             win_q;
	logic             cmp_pend_q;
	logic [PW-1:0]    lhs_q;
	logic [PW-1:0]    rhs_q;
	logic             out_valid_q;
	item_out_t        out_data_q;

	logic             div_start;
	logic [TW-1:0]    div_b;
	logic             div_done;
	logic [TW-1:0]    div_quo;
	logic [TW-1:0]    div_rem;

	logic [TW-1:0]    elapsed;
	logic [TW-1:0]    mult;
	logic [TW-1:0]    mult_raw;
	logic [TW-1:0]    pa;
	logic [TW-1:0]    ia;
	logic [3:0]       low_sum;
	logic [TW:0]      smooth_sum;
	logic [PCT_W-1:0] pct_eff;
	logic [PW-1:0]    pos_inc;
	logic [LEN_W-1:0] qlen_clamped;
	logic             fire;
	logic             out_load;
	logic [63:0]      period_ext;

	assign elapsed = now_q - anchor_q;

	// Rounded multiple of the period in the interval, never below one.
	assign mult_raw = div_quo + TW'(div_rem >= (period_q - (period_q >> 1)));
	assign mult     = (mult_raw == '0) ? TW'(1) : mult_raw;

	// New period = 3/4 old + 1/4 implied, with the low bits summed separately.
	assign pa         = period_q >> 2;
	assign ia         = div_quo >> 2;
	assign low_sum    = 4'(period_q[1:0]) * 4'd3 + 4'(div_quo[1:0]);
	assign smooth_sum = (TW+1)'(pa) + ((TW+1)'(pa) << 1) + (TW+1)'(ia)
		+ (TW+1)'(low_sum >> 2);

	assign pct_eff = (pct_q > PCT_FULL) ? PCT_FULL : pct_q;
	// pos < floor(p * s / 100) holds exactly when 100 * (pos + 1) <= p * s.
	assign pos_inc = PW'(div_rem) + PW'(1);

	assign qlen_clamped = (in_data.queue_length > LEN_MAX) ? LEN_MAX
		: in_data.queue_length;

	assign fire = (queued_q != '0) && !radio_busy_q
		&& ((op_q == OP_DOWNLINK) || ((op_q == OP_TICK) && win_q));

	assign out_load = (state_q == S_DONE) && !cmp_pend_q && (!out_valid_q || out_ready);

	assign period_ext = 64'(period_q);

	assign div_start = ((state_q == S_PREP) && (op_q == OP_DOWNLINK) && anchor_vld_q
			&& (period_q != '0))
		|| ((state_q == S_QUOT) && div_done)
		|| ((state_q == S_WIN) && (period_q != '0));
	assign div_b = (state_q == S_QUOT) ? mult : period_q;

	dcug_div #(
		.W(TW)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (elapsed),
		.divisor   (div_b),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			anchor_q     <= '0;
			anchor_vld_q <= 1'b0;
			period_q     <= '0;
			queued_q     <= '0;
			pct_q        <= PCT_RESET;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				pct_q <= cfg_data;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						if (in_data.opcode == OP_QUEUE) begin
							queued_q <= qlen_clamped;
						end
						state_q <= S_PREP;
					end
				end
				S_PREP: begin
					if (op_q == OP_DOWNLINK) begin
						if (anchor_vld_q && (period_q != '0)) begin
							state_q <= S_QUOT;
						end else begin
							if (anchor_vld_q) begin
								period_q <= elapsed;
							end
							anchor_q     <= now_q;
							anchor_vld_q <= 1'b1;
							state_q      <= S_WIN;
						end
					end else begin
						state_q <= S_WIN;
					end
				end
				S_QUOT: begin
					if (div_done) begin
						state_q <= S_IMPL;
					end
				end
				S_IMPL: begin
					if (div_done) begin
						state_q <= S_SMOOTH;
					end
				end
				S_SMOOTH: begin
					period_q <= smooth_sum[TW-1:0];
					anchor_q <= now_q;
					state_q  <= S_WIN;
				end
				S_WIN: begin
					state_q <= (period_q == '0) ? S_DONE : S_MOD;
				end
				S_MOD: begin
					if (div_done) begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_load) begin
						if (fire) begin
							queued_q <= '0;
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// The product compare lands in win_q in the cycle after the done state is entered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmp_pend_q <= 1'b0;
		end else begin
			cmp_pend_q <= (state_q == S_MUL);
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_q         <= in_data.opcode;
			now_q        <= TW'(in_data.now_ms);
			radio_busy_q <= in_data.radio_busy;
		end
		if ((state_q == S_WIN) && (period_q == '0)) begin
			win_q <= 1'b1;
		end else if (cmp_pend_q) begin
			win_q <= (lhs_q <= rhs_q);
		end
		if (state_q == S_MUL) begin
			lhs_q <= pos_inc * PW'(PCT_FULL);
			rhs_q <= PW'(period_q) * PW'(pct_eff);
		end
		if (out_load) begin
			out_data_q.send_fire   <= fire;
			out_data_q.send_length <= fire ? queued_q : '0;
			out_data_q.in_window   <= win_q;
			out_data_q.cadence_ms  <= period_ext[NOW_W-1:0];
			out_data_q.pending     <= (queued_q != '0) && !fire;
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	a_unlearned_safe: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_DONE) && !cmp_pend_q && (period_q == '0)) |-> win_q)
		else $error("window closed while no period is learned");

	a_fire_length: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_data_q.send_fire == (out_data_q.send_length != '0)))
		else $error("fire flag and send length disagree");

	a_fire_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_data_q.send_fire) |-> !out_data_q.pending)
		else $error("uplink still pending after it fired");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("second event taken while one is in work");

endmodule

`default_nettype wire

FILE: dv/dcug_report_checker.sv
`timescale 1ns / 1ps

// Watches the event, report and percent channels of the uplink gate, keeps its
// own copy of the cadence state and compares every report with the prediction.
module dcug_report_checker
	import dcug_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	input  wire logic             in_ready,
	input  wire item_in_t         in_data,
	input  wire logic             out_valid,
	input  wire logic             out_ready,
	input  wire item_out_t        out_data,
	input  wire logic             cfg_valid,
	input  wire logic             cfg_ready,
	input  wire logic [PCT_W-1:0] cfg_data,
	output int unsigned           mismatches,
	output int unsigned           reports_due
);

	localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(DEF_MAX_PAYLOAD);

	logic [NOW_W-1:0] anchor_ms;
	logic             anchor_seen;
	logic [NOW_W-1:0] cadence;
	logic [LEN_W-1:0] queued_len;
	logic [PCT_W-1:0] safe_pct;
	item_out_t        expected_reports[$];
	int unsigned      report_num;

	function automatic logic in_safe_window(input logic [NOW_W-1:0] now);
		logic [NOW_W-1:0] since;
		logic [63:0]      per;
		logic [63:0]      pct;
		logic [63:0]      pos;
		logic [63:0]      limit;
		if (cadence == '0) begin
			return 1'b1;
		end
		since = now - anchor_ms;
		per = {32'd0, cadence};
		pct = (safe_pct > PCT_FULL) ? 64'(PCT_FULL) : 64'(safe_pct);
		pos = {32'd0, since % cadence};
		limit = (per / 100) * pct + ((per % 100) * pct) / 100;
		return pos < limit;
	endfunction

	// Refines the period from the interval since the last downlink, counting
	// missed bursts by rounding the interval to a multiple of the period.
	function automatic void take_downlink(input logic [NOW_W-1:0] now);
		logic [NOW_W-1:0] span;
		logic [NOW_W-1:0] implied;
		logic [NOW_W-1:0] mult;
		logic [63:0]      old_p;
		logic [63:0]      new_p;
		logic [63:0]      blend;
		if (anchor_seen) begin
			span = now - anchor_ms;
			implied = span;
			if (cadence != '0) begin
				mult = span / cadence;
				if (span % cadence >= cadence - (cadence >> 1)) begin
					mult = mult + 1;
				end
				if (mult == '0) begin
					mult = 1;
				end
				implied = span / mult;
			end
			if (cadence == '0) begin
				cadence = implied;
			end else begin
				old_p = {32'd0, cadence};
				new_p = {32'd0, implied};
				blend = 3 * (old_p >> 2) + (new_p >> 2) + (3 * (old_p & 3) + (new_p & 3)) / 4;
				cadence = blend[NOW_W-1:0];
			end
		end
		anchor_ms = now;
		anchor_seen = 1'b1;
	endfunction

	function automatic logic [LEN_W-1:0] release_uplink(input logic busy);
		logic [LEN_W-1:0] len;
		len = queued_len;
		if (len == '0 || busy) begin
			return '0;
		end
		queued_len = '0;
		return len;
	endfunction

	function automatic item_out_t predict_report(input item_in_t ev);
		item_out_t        rep;
		logic [LEN_W-1:0] fired;
		fired = '0;
		case (ev.opcode)
			OP_TICK: begin
				if (queued_len != '0 && in_safe_window(ev.now_ms)) begin
					fired = release_uplink(ev.radio_busy);
				end
			end
			OP_DOWNLINK: begin
				take_downlink(ev.now_ms);
				fired = release_uplink(ev.radio_busy);
			end
			OP_QUEUE: begin
				queued_len = (ev.queue_length > LEN_CAP) ? LEN_CAP : ev.queue_length;
			end
			default: begin
			end
		endcase
		rep.send_fire = (fired != '0);
		rep.send_length = fired;
		rep.in_window = in_safe_window(ev.now_ms);
		rep.cadence_ms = cadence;
		rep.pending = (queued_len != '0);
		return rep;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		item_out_t want;
		if (!arst_n) begin
			anchor_ms = '0;
			anchor_seen = 1'b0;
			cadence = '0;
			queued_len = '0;
			safe_pct = PCT_RESET;
			expected_reports.delete();
			mismatches = 0;
			report_num = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				safe_pct = cfg_data;
			end
			if (in_valid && in_ready) begin
				expected_reports.push_back(predict_report(in_data));
			end
			if (out_valid && out_ready) begin
				report_num++;
				if (expected_reports.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("report %0d arrived with no event waiting for it", report_num);
					end
				end else begin
					want = expected_reports.pop_front();
					if (out_data.send_fire !== want.send_fire
							|| out_data.send_length !== want.send_length
							|| out_data.in_window !== want.in_window
							|| out_data.cadence_ms !== want.cadence_ms
							|| out_data.pending !== want.pending) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("report %0d: expected fire=%0d len=%0d win=%0d cad=%0d pend=%0d",
								report_num, want.send_fire, want.send_length, want.in_window,
								want.cadence_ms, want.pending);
							$display("report %0d:      got fire=%0d len=%0d win=%0d cad=%0d pend=%0d",
								report_num, out_data.send_fire, out_data.send_length,
								out_data.in_window, out_data.cadence_ms, out_data.pending);
						end
					end
				end
			end
		end
		reports_due = expected_reports.size();
	end

endmodule

FILE: dv/tb_downlink_cadence_uplink_gate_top.sv
`timescale 1ns / 1ps

module tb_downlink_cadence_uplink_gate_top;
	import dcug_pkg::*;

	localparam int unsigned WATCHDOG_LIMIT = 5000;
	localparam int unsigned HOLD_CYCLES    = 600;
	localparam int unsigned TAIL_CYCLES    = 3 * NOW_W + 20;
	localparam int unsigned PHASE_ITEMS    = 255;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             in_valid;
	logic             in_ready;
	item_in_t         in_data;
	logic             out_valid;
	logic             out_ready;
	item_out_t        out_data;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [PCT_W-1:0] cfg_data;

	int unsigned mismatches;
	int unsigned reports_due;
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned quiet_cycles = 0;
	logic        long_hold_req = 1'b0;

	always #2 clk = ~clk;

	downlink_cadence_uplink_gate_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	dcug_report_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_data    (out_data),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.mismatches  (mismatches),
		.reports_due (reports_due)
	);

	function automatic item_in_t make_event(input op_t op, input logic [NOW_W-1:0] now,
			input logic busy, input logic [LEN_W-1:0] len);
		item_in_t ev;
		ev.opcode = op;
		ev.now_ms = now;
		ev.radio_busy = busy;
		ev.queue_length = len;
		return ev;
	endfunction

	// Called at a falling edge; returns at the falling edge after the transaction.
	task automatic push_event(input item_in_t ev);
		int unsigned gap;
		gap = 0;
		while (gap < 12 && $urandom_range(99) < send_idle_pct) begin
			gap++;
		end
		if (gap != 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		in_data = ev;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		in_valid = 1'b0;
		while (reports_due != 0) begin
			@(negedge clk);
		end
	endtask

	task automatic write_safe_pct(input logic [PCT_W-1:0] pct);
		wait_drained();
		cfg_valid = 1'b1;
		cfg_data = pct;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Ticks, the most common event, downlinks on a steady cadence with jitter and
	// missed bursts, and queued uplinks; the rest is noise with arbitrary times.
	task automatic run_cadence_phase(input int unsigned n_items, input logic with_pressure);
		int unsigned      sent;
		int unsigned      left;
		int unsigned      roll;
		int unsigned      k;
		logic [NOW_W-1:0] period_ms;
		logic [NOW_W-1:0] last_dl;
		logic [NOW_W-1:0] spread;
		logic [NOW_W-1:0] offs;
		logic [LEN_W-1:0] len;
		item_in_t         ev;
		sent = 0;
		left = 0;
		period_ms = 1;
		last_dl = '0;
		while (sent < n_items) begin
			if (left == 0) begin
				left = $urandom_range(20, 80);
				roll = $urandom_range(99);
				if (roll < 70) begin
					period_ms = $urandom_range(8, 3000);
				end else if (roll < 88) begin
					period_ms = $urandom_range(1, 7);
				end else begin
					period_ms = $urandom_range(32'h0010_0000, 32'hFFFF_FFFF);
				end
				last_dl = $urandom;
			end
			left--;
			roll = $urandom_range(99);
			if (roll < 25) begin
				k = ($urandom_range(9) == 0) ? $urandom_range(2, 4) : 1;
				spread = period_ms >> 3;
				last_dl = last_dl + k * period_ms + $urandom_range(0, spread) - (spread >> 1);
				ev = make_event(OP_DOWNLINK, last_dl, $urandom_range(3) == 0,
					LEN_W'($urandom));
			end else if (roll < 65) begin
				offs = $urandom_range(0, period_ms);
				if ($urandom_range(3) == 0) begin
					offs = offs + period_ms;
				end
				ev = make_event(OP_TICK, last_dl + offs, $urandom_range(3) == 0,
					LEN_W'($urandom));
			end else if (roll < 85) begin
				case ($urandom_range(19))
					0: len = '0;
					1: len = LEN_W'($urandom_range(257, 511));
					2: len = LEN_W'(DEF_MAX_PAYLOAD);
					default: len = LEN_W'($urandom_range(1, 255));
				endcase
				ev = make_event(OP_QUEUE, $urandom, 1'($urandom_range(1)), len);
			end else begin
				ev = make_event(op_t'($urandom_range(3)), $urandom, 1'($urandom_range(1)),
					LEN_W'($urandom));
			end
			push_event(ev);
			if (ev.opcode != OP_NONE) begin
				sent++;
				if (with_pressure && sent == n_items / 4) begin
					wait_drained();
				end
				if (with_pressure && sent == n_items / 2) begin
					long_hold_req = 1'b1;
				end
			end
		end
	endtask

	// Receiver: random stalls, plus one long hold-off on request.
	initial begin
		logic hold_taken;
		hold_taken = 1'b0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (long_hold_req && !hold_taken) begin
				out_ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_taken = 1'b1;
			end
			out_ready = ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Ends the run when no transaction of any kind happens for too long.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	initial begin
		logic [PCT_W-1:0] pct_set [6];
		int unsigned      send_mode [6];
		int unsigned      recv_mode [6];
		pct_set = '{7'd0, PCT_FULL, 7'd127, 7'd50, 7'd1, PCT_RESET};
		send_mode = '{0, 45, 0, 37, 0, 37};
		recv_mode = '{0, 0, 45, 37, 0, 37};
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Nothing learned yet: every time is safe; clear, clamp and busy handling.
		push_event(make_event(OP_TICK, 32'd0, 1'b0, 9'd0));
		push_event(make_event(OP_QUEUE, 32'd1, 1'b0, 9'd0));
		push_event(make_event(OP_QUEUE, 32'd2, 1'b1, 9'h1FF));
		push_event(make_event(OP_TICK, 32'd5, 1'b1, 9'd0));
		push_event(make_event(OP_TICK, 32'd6, 1'b0, 9'd0));
		// A downlink at time zero still sets the anchor; a run of zero intervals
		// then smooths the period back down to zero.
		push_event(make_event(OP_QUEUE, 32'd7, 1'b0, 9'd1));
		push_event(make_event(OP_DOWNLINK, 32'd0, 1'b1, 9'd0));
		repeat (4) push_event(make_event(OP_DOWNLINK, 32'd3, 1'b1, 9'd0));
		push_event(make_event(OP_TICK, 32'd100, 1'b0, 9'd0));
		push_event(make_event(OP_NONE, 32'hFFFF_FFFF, 1'b1, 9'h1FF));
		// Interval across the wrap of the millisecond counter.
		push_event(make_event(OP_QUEUE, 32'hFFFF_FFFF, 1'b0, 9'd256));
		push_event(make_event(OP_DOWNLINK, 32'hFFFF_FFF0, 1'b1, 9'h1FF));
		push_event(make_event(OP_DOWNLINK, 32'h0000_0010, 1'b1, 9'd0));
		push_event(make_event(OP_TICK, 32'h0000_0011, 1'b0, 9'd0));
		push_event(make_event(OP_QUEUE, 32'h8000_0000, 1'b0, 9'd257));
		push_event(make_event(OP_DOWNLINK, 32'hFFFF_FFFF, 1'b1, 9'd0));
		push_event(make_event(OP_TICK, 32'h7FFF_FFFF, 1'b0, 9'd0));
		push_event(make_event(OP_DOWNLINK, 32'h7FFF_FFFF, 1'b0, 9'd0));

		pct_set[3] = PCT_W'($urandom_range(2, 99));
		for (int ph = 0; ph < 6; ph++) begin
			write_safe_pct(pct_set[ph]);
			send_idle_pct = send_mode[ph];
			recv_stall_pct = recv_mode[ph];
			run_cadence_phase(PHASE_ITEMS, ph == 0);
		end

		wait_drained();
		repeat (TAIL_CYCLES) @(negedge clk);
		if (mismatches == 0 && reports_due == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

FILE: downlink_cadence_uplink_gate_top.f
hw/rtl/dcug_pkg.sv
hw/rtl/dcug_div.sv
hw/rtl/downlink_cadence_uplink_gate_top.sv
dv/dcug_report_checker.sv
dv/tb_downlink_cadence_uplink_gate_top.sv
